// ----- rtl/lce_pkg.sv -----
// ----------------------------------------------------------------------------
// lce_pkg
// Shared types and constants of the cellular automaton engine.
// ----------------------------------------------------------------------------
package lce_pkg;

  localparam int unsigned MaxSideDef = 64;
  localparam int unsigned OpW        = 2;
  localparam int unsigned PosW       = 7;
  localparam int unsigned CfgW       = 7;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CountW     = 13;

  localparam logic [OpW-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OpW-1:0] OP_TOGGLE = 2'd1;
  localparam logic [OpW-1:0] OP_STEP   = 2'd2;
  localparam logic [OpW-1:0] OP_READ   = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_WRAP   = 2'd2;

  typedef struct packed {
    logic accept;
    logic pre;
    logic pre2;
    logic load;
    logic visit;
    logic wb;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic last_col;
    logic last_row;
    logic out_busy;
  } sts_t;

endpackage

// ----- rtl/lce_if.sv -----
// ----------------------------------------------------------------------------
// lce_in_if / lce_out_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface lce_in_if;
  import lce_pkg::*;
  logic            valid;
  logic            ready;
  logic [OpW-1:0]  op;
  logic [PosW-1:0] col;
  logic [PosW-1:0] row;
  modport source (output valid, output op, output col, output row, input ready);
  modport sink   (input valid, input op, input col, input row, output ready);
endinterface

interface lce_out_if;
  import lce_pkg::*;
  logic              valid;
  logic              ready;
  logic              cell_alive;
  logic [CountW-1:0] live_count;
  modport source (output valid, output cell_alive, output live_count, input ready);
  modport sink   (input valid, input cell_alive, input live_count, output ready);
endinterface

// ----- rtl/lce_ctrl.sv -----
// ----------------------------------------------------------------------------
// lce_ctrl
// Sequencer of the board sweep: row loads, cell steps, write-back, result.
// ----------------------------------------------------------------------------
module lce_ctrl
  import lce_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRE  = 3'd1;
  localparam logic [2:0] S_PRE2 = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_CELL = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_q, state_d;
  logic       silent_q, silent_d;

  always_comb begin
    state_d  = state_q;
    silent_d = silent_q;
    cmd_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_PRE;
        end
      end
      S_PRE: begin
        cmd_o.pre = 1'b1;
        state_d   = S_PRE2;
      end
      S_PRE2: begin
        cmd_o.pre2 = 1'b1;
        state_d    = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_CELL;
      end
      S_CELL: begin
        cmd_o.visit = 1'b1;
        if (sts_i.last_col) state_d = S_WB;
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        state_d  = sts_i.last_row ? S_DONE : S_CELL;
      end
      S_DONE: begin
        if (silent_q) begin
          silent_d = 1'b0;
          state_d  = S_IDLE;
        end else if (!sts_i.out_busy) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_PRE;
      silent_q <= 1'b1;
    end else begin
      state_q  <= state_d;
      silent_q <= silent_d;
    end
  end

endmodule

// ----- rtl/lce_dp.sv -----
// ----------------------------------------------------------------------------
// lce_dp
// Board memory, row buffers, cell update, live counter and result register.
// ----------------------------------------------------------------------------
module lce_dp
  import lce_pkg::*;
#(
  parameter int unsigned MAX_SIDE = MaxSideDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic [OpW-1:0]      in_op_i,
  input  logic [PosW-1:0]     in_col_i,
  input  logic [PosW-1:0]     in_row_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_alive_o,
  output logic [CountW-1:0]   out_count_o
);

  localparam int unsigned RW = $clog2(MAX_SIDE);
  localparam int unsigned SW = $clog2(MAX_SIDE + 1);
  localparam int unsigned KW = (SW > PosW) ? SW : PosW;
  localparam logic [KW-1:0] SideMax = KW'(MAX_SIDE);
  localparam logic [KW-1:0] SideMin = KW'(3);
  localparam logic [CountW-1:0] CountSat = {CountW{1'b1}};

  logic [CfgW-1:0] width_q, height_q;
  logic            wrap_q;
  logic [KW-1:0]   w, h, width_k, height_k;

  logic [MAX_SIDE-1:0] mem [MAX_SIDE];
  logic [MAX_SIDE-1:0] rdata_q, prev_q, cur_q, first_q, new_q, next_rule;
  logic                re;
  logic [RW-1:0]       raddr;

  logic [RW-1:0]     r_q, c_q, cl, cr;
  logic [OpW-1:0]    op_q;
  logic [PosW-1:0]   col_q, row_q;
  logic              inr_q;
  logic [CountW-1:0] count_q;
  logic              alive_q;
  logic              out_valid_q, out_alive_q;
  logic [CountW-1:0] out_count_q;

  logic [KW-1:0] r1, c1, col_k, row_k;
  logic [RW:0]   r2;
  logic          lv, rv, in_area, target, self, newbit;
  logic [3:0]    n;

  assign width_k  = KW'(width_q);
  assign height_k = KW'(height_q);
  assign w = (width_k < SideMin) ? SideMin : ((width_k > SideMax) ? SideMax : width_k);
  assign h = (height_k < SideMin) ? SideMin : ((height_k > SideMax) ? SideMax : height_k);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(64);
      height_q <= CfgW'(64);
      wrap_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        REG_WRAP:   wrap_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign r1    = KW'(r_q) + KW'(1);
  assign c1    = KW'(c_q) + KW'(1);
  assign r2    = {1'b0, r_q} + (RW+1)'(2);
  assign col_k = KW'(col_q);
  assign row_k = KW'(row_q);

  always_comb begin
    re    = 1'b0;
    raddr = '0;
    if (cmd_i.pre) begin
      re    = 1'b1;
      raddr = RW'(h - KW'(1));
    end else if (cmd_i.pre2) begin
      re    = 1'b1;
      raddr = '0;
    end else if (cmd_i.load) begin
      re    = 1'b1;
      raddr = RW'(1);
    end else if (cmd_i.wb) begin
      re    = (r2 < (RW+1)'(MAX_SIDE));
      raddr = r2[RW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) rdata_q <= mem[raddr];
    if (cmd_i.wb) mem[r_q] <= new_q;
  end

  assign next_rule = (r1 < h) ? rdata_q : (wrap_q ? first_q : '0);

  assign cl = (c_q == '0) ? RW'(w - KW'(1)) : (c_q - RW'(1));
  assign lv = (c_q != '0) || wrap_q;
  assign cr = (c1 == w) ? '0 : RW'(c1);
  assign rv = (c1 != w) || wrap_q;

  assign self = cur_q[c_q];
  assign n = 4'(prev_q[cl] & lv) + 4'(prev_q[c_q]) + 4'(prev_q[cr] & rv)
           + 4'(cur_q[cl] & lv) + 4'(self) + 4'(cur_q[cr] & rv)
           + 4'(next_rule[cl] & lv) + 4'(next_rule[c_q]) + 4'(next_rule[cr] & rv);

  assign in_area = (KW'(r_q) < h) && (KW'(c_q) < w);
  assign target  = inr_q && (r1 == row_k) && (c1 == col_k);

  always_comb begin
    case (op_q)
      OP_CLEAR:  newbit = 1'b0;
      OP_TOGGLE: newbit = self ^ target;
      OP_STEP:   newbit = in_area ? (self ? (n == 4'd3 || n == 4'd4) : (n == 4'd3)) : self;
      default:   newbit = self;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_CLEAR;
      r_q  <= '0;
      c_q  <= '0;
    end else begin
      if (cmd_i.accept) op_q <= in_op_i;
      if (cmd_i.pre) begin
        r_q <= '0;
        c_q <= '0;
      end else if (cmd_i.visit) begin
        c_q <= c_q + RW'(1);
      end else if (cmd_i.wb) begin
        c_q <= '0;
        r_q <= r_q + RW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      col_q <= in_col_i;
      row_q <= in_row_i;
      inr_q <= (in_col_i != '0) && (KW'(in_col_i) <= w)
            && (in_row_i != '0) && (KW'(in_row_i) <= h);
    end
    if (cmd_i.pre) begin
      count_q <= '0;
      alive_q <= 1'b0;
    end
    if (cmd_i.pre2) prev_q <= wrap_q ? rdata_q : '0;
    if (cmd_i.load) begin
      cur_q   <= rdata_q;
      first_q <= rdata_q;
    end
    if (cmd_i.visit) begin
      new_q[c_q] <= newbit;
      if (in_area && newbit && count_q != CountSat) count_q <= count_q + CountW'(1);
      if (target) alive_q <= newbit;
    end
    if (cmd_i.wb) begin
      prev_q <= cur_q;
      cur_q  <= rdata_q;
    end
    if (cmd_i.publish) begin
      out_alive_q <= alive_q;
      out_count_q <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.last_col = (c_q == RW'(MAX_SIDE - 1));
  assign sts_o.last_row = (r_q == RW'(MAX_SIDE - 1));
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_alive_o = out_alive_q;
  assign out_count_o = out_count_q;

endmodule

// ----- rtl/life_cellular_automaton_engine_unit.sv -----
// ----------------------------------------------------------------------------
// life_cellular_automaton_engine_unit
// B3/S23 cellular automaton on a one-bit board with clear, toggle, step, read.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake     Payload
// in_i     input      valid/ready   op, col, row
// out_o    output     valid/ready   cell_alive, live_count
// cfg      input      cfg_we_i      cfg_idx_i, cfg_data_i
//
// Every item sweeps the whole store one cell per cycle, MAX_SIDE rows of
// MAX_SIDE cells plus a write-back step per row; the row memory has a
// single read port. After reset a clearing pass runs first.
// A result that is not taken holds the engine before its next result.
// ----------------------------------------------------------------------------
module life_cellular_automaton_engine_unit
  import lce_pkg::*;
#(
  parameter int unsigned MAX_SIDE = MaxSideDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  lce_in_if.sink             in_i,
  lce_out_if.source          out_o
);

  cmd_t cmd;
  sts_t sts;

  lce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lce_dp #(.MAX_SIDE(MAX_SIDE)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_op_i     (in_i.op),
    .in_col_i    (in_i.col),
    .in_row_i    (in_i.row),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_alive_o (out_o.cell_alive),
    .out_count_o (out_o.live_count)
  );

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("engine still ready after taking an item");

  a_publish_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |-> (!out_o.valid || out_o.ready))
    else $error("result published over a pending result");

  a_publish_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |-> !in_i.ready)
    else $error("result published while idle");

endmodule
